// ===== src/sddd_pkg.sv =====
// ----------------------------------------------------------------------------
// Signed date difference package
// Shared types, constants and helper functions for the date difference unit.
// ----------------------------------------------------------------------------
package sddd_pkg;

   localparam int DEFAULT_MAX_YEAR = 9999;
   // Largest year that a 14-bit year field can carry.
   localparam int YEAR_FIELD_MAX   = 16383;

   localparam int DAY_WIDTH    = 5;
   localparam int MONTH_WIDTH  = 4;
   localparam int YEAR_WIDTH   = 14;
   localparam int RESULT_WIDTH = 23;

   // Quarter-year count divided by 25 through a reciprocal multiply.
   localparam int RECIP_25      = 2621;
   localparam int RECIP_SHIFT   = 16;
   localparam int RECIP_WIDTH   = 24;
   localparam int CENTURY_WIDTH = 8;

   localparam int SERIAL_LATENCY = 4;
   localparam int PIPE_LATENCY   = SERIAL_LATENCY + 2;

   typedef struct packed {
      logic [DAY_WIDTH-1:0]   day;
      logic [MONTH_WIDTH-1:0] month;
      logic [YEAR_WIDTH-1:0]  year;
   } date_type;

   function automatic int year_cap(input int max_year);
      return (max_year < YEAR_FIELD_MAX) ? max_year : YEAR_FIELD_MAX;
   endfunction

   function automatic int serial_width(input int max_year);
      return $clog2(year_cap(max_year) * 366 + 32);
   endfunction

   // Days in the whole months before the given month of a common year.
   function automatic logic [8:0] days_before_month(input logic [MONTH_WIDTH-1:0] month);
      logic [8:0] days;
      case (month)
         4'd1:    days = 9'd0;
         4'd2:    days = 9'd31;
         4'd3:    days = 9'd59;
         4'd4:    days = 9'd90;
         4'd5:    days = 9'd120;
         4'd6:    days = 9'd151;
         4'd7:    days = 9'd181;
         4'd8:    days = 9'd212;
         4'd9:    days = 9'd243;
         4'd10:   days = 9'd273;
         4'd11:   days = 9'd304;
         4'd12:   days = 9'd334;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

endpackage

// ===== src/sddd_serial.sv =====
// ----------------------------------------------------------------------------
// Serial day number pipeline
// Turns one calendar date into its serial day number over four register
// stages: clamping, constant multiplies, century correction, leap adjust.
// ----------------------------------------------------------------------------
module sddd_serial #(
   parameter int MAX_YEAR = sddd_pkg::DEFAULT_MAX_YEAR
) (
   input  logic                                          clock,
   input  sddd_pkg::date_type                            date_i,
   output logic [sddd_pkg::serial_width(MAX_YEAR)-1:0]   serial_o
);
   import sddd_pkg::*;

   localparam int SerialWidth = serial_width(MAX_YEAR);
   localparam int YearCap     = year_cap(MAX_YEAR);

   // Stage 1: clamped date and year minus one.
   logic [DAY_WIDTH-1:0]   day1_ff;
   logic [MONTH_WIDTH-1:0] month1_ff, month1_in;
   logic [YEAR_WIDTH-1:0]  year1_ff, year1_in;
   logic [YEAR_WIDTH-1:0]  prev1_ff;

   // Stage 2: products and month table.
   logic [DAY_WIDTH-1:0]     day2_ff;
   logic [YEAR_WIDTH-1:0]    prev2_ff;
   logic [CENTURY_WIDTH-1:0] cent_est2_ff;
   logic [SerialWidth-1:0]   prev365_2_ff;
   logic [8:0]               dbm2_ff;
   logic                     late2_ff;
   logic                     four2_ff;
   logic [RECIP_WIDTH-1:0]   recip_prod;

   // Stage 3: corrected century count and partial sum.
   logic [CENTURY_WIDTH-1:0] cent3_ff;
   logic [6:0]               rem3_ff;
   logic [SerialWidth-1:0]   part3_ff, part3_in;
   logic                     late3_ff;
   logic                     four3_ff;
   logic [YEAR_WIDTH-1:0]    rem_wide;
   logic [7:0]               rem_est;
   logic                     cent_fix;

   // Stage 4: serial day number.
   logic [SerialWidth-1:0] serial_ff, serial_in;
   logic                   leap;

   always_comb begin
      if (date_i.month == '0) begin
         month1_in = MONTH_WIDTH'(1);
      end else if (date_i.month > MONTH_WIDTH'(12)) begin
         month1_in = MONTH_WIDTH'(12);
      end else begin
         month1_in = date_i.month;
      end
      if (date_i.year == '0) begin
         year1_in = YEAR_WIDTH'(1);
      end else if (date_i.year > YEAR_WIDTH'(YearCap)) begin
         year1_in = YEAR_WIDTH'(YearCap);
      end else begin
         year1_in = date_i.year;
      end
   end

   always_ff @(posedge clock) begin
      day1_ff   <= date_i.day;
      month1_ff <= month1_in;
      year1_ff  <= year1_in;
      prev1_ff  <= year1_in - YEAR_WIDTH'(1);
   end

   // The reciprocal estimate of the year count over 100 is exact or one low.
   assign recip_prod = RECIP_WIDTH'(prev1_ff[YEAR_WIDTH-1:2]) * RECIP_WIDTH'(RECIP_25);

   always_ff @(posedge clock) begin
      day2_ff      <= day1_ff;
      prev2_ff     <= prev1_ff;
      cent_est2_ff <= recip_prod[RECIP_SHIFT +: CENTURY_WIDTH];
      prev365_2_ff <= SerialWidth'(prev1_ff) * SerialWidth'(365);
      dbm2_ff      <= days_before_month(month1_ff);
      late2_ff     <= month1_ff > MONTH_WIDTH'(2);
      four2_ff     <= year1_ff[1:0] == 2'b00;
   end

   always_comb begin
      rem_wide = prev2_ff - YEAR_WIDTH'(cent_est2_ff) * YEAR_WIDTH'(100);
      rem_est  = rem_wide[7:0];
      cent_fix = rem_est >= 8'd100;
      part3_in = prev365_2_ff + SerialWidth'(prev2_ff[YEAR_WIDTH-1:2])
               + SerialWidth'(dbm2_ff) + SerialWidth'(day2_ff);
   end

   always_ff @(posedge clock) begin
      cent3_ff <= cent_est2_ff + CENTURY_WIDTH'(cent_fix);
      rem3_ff  <= 7'(rem_est - (cent_fix ? 8'd100 : 8'd0));
      part3_ff <= part3_in;
      late3_ff <= late2_ff;
      four3_ff <= four2_ff;
   end

   // The year is a century year when (year - 1) mod 100 is 99, and a multiple
   // of 400 when in addition the count of whole centuries is 3 mod 4.
   always_comb begin
      leap      = four3_ff && ((rem3_ff != 7'd99) || (cent3_ff[1:0] == 2'b11));
      serial_in = part3_ff - SerialWidth'(cent3_ff)
                + SerialWidth'(cent3_ff[CENTURY_WIDTH-1:2])
                + SerialWidth'(late3_ff && leap);
   end

   always_ff @(posedge clock) begin
      serial_ff <= serial_in;
   end

   assign serial_o = serial_ff;

endmodule

// ===== src/signed_date_difference_days_unit.sv =====
// ----------------------------------------------------------------------------
// Signed date difference unit
// Signed count of days from a first to a second Gregorian date.
// ----------------------------------------------------------------------------
//  Channel   Ports                               Handshake
//  request   req_first_*, req_second_*,          start high while busy low
//            req_count_end_day
//  response  rsp_day_difference                  rsp_valid strobe, one cycle
//
// Each request taken is answered, and a new request can be taken in every cycle
// in which busy is low, as it is outside reset: the two date conversions and the
// difference each run through their own register stages.
// Synchronous reset clears the valid pipeline and holds busy high for the
// reset cycles, so no request in flight survives a reset.
// The response side cannot stall, so nothing ever backs up.
module signed_date_difference_days_unit #(
   parameter int MAX_YEAR = sddd_pkg::DEFAULT_MAX_YEAR
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic [sddd_pkg::DAY_WIDTH-1:0]          req_first_day,
   input  logic [sddd_pkg::MONTH_WIDTH-1:0]        req_first_month,
   input  logic [sddd_pkg::YEAR_WIDTH-1:0]         req_first_year,
   input  logic [sddd_pkg::DAY_WIDTH-1:0]          req_second_day,
   input  logic [sddd_pkg::MONTH_WIDTH-1:0]        req_second_month,
   input  logic [sddd_pkg::YEAR_WIDTH-1:0]         req_second_year,
   input  logic                                    req_count_end_day,
   output logic                                    rsp_valid,
   output logic signed [sddd_pkg::RESULT_WIDTH-1:0] rsp_day_difference
);
   import sddd_pkg::*;

   localparam int SerialWidth = serial_width(MAX_YEAR);
   localparam int DiffWidth   = SerialWidth + 1;

   date_type               first_date, second_date;
   logic [SerialWidth-1:0] first_serial, second_serial;

   logic                      accept;
   logic                      busy_ff;
   logic [PIPE_LATENCY-1:0]   valid_ff, valid_in;
   logic [SERIAL_LATENCY-1:0] end_ff, end_in;

   logic signed [DiffWidth-1:0] diff_ff, diff_in;
   logic                        later_ff;
   logic                        end5_ff;
   logic signed [DiffWidth-1:0] result_ff, result_in;

   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign first_date  = '{day: req_first_day, month: req_first_month, year: req_first_year};
   assign second_date = '{day: req_second_day, month: req_second_month,
                          year: req_second_year};

   sddd_serial #(.MAX_YEAR(MAX_YEAR)) u_first_serial (
      .clock    (clock),
      .date_i   (first_date),
      .serial_o (first_serial)
   );

   sddd_serial #(.MAX_YEAR(MAX_YEAR)) u_second_serial (
      .clock    (clock),
      .date_i   (second_date),
      .serial_o (second_serial)
   );

   // The end-day flag rides alongside the conversion pipeline.
   assign end_in   = {end_ff[SERIAL_LATENCY-2:0], req_count_end_day};
   assign valid_in = {valid_ff[PIPE_LATENCY-2:0], accept};

   always_ff @(posedge clock) begin
      end_ff <= end_in;
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign diff_in = $signed({1'b0, second_serial}) - $signed({1'b0, first_serial});

   always_ff @(posedge clock) begin
      diff_ff  <= diff_in;
      later_ff <= first_serial < second_serial;
      end5_ff  <= end_ff[SERIAL_LATENCY-1];
   end

   // The end day moves the count one further from zero; equal dates go negative.
   always_comb begin
      if (later_ff) begin
         result_in = diff_ff + DiffWidth'(end5_ff);
      end else begin
         result_in = diff_ff - DiffWidth'(end5_ff);
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_valid          = valid_ff[PIPE_LATENCY-1];
   assign rsp_day_difference = RESULT_WIDTH'(result_ff);

endmodule

// ===== src/sddd_checker.sv =====
// ----------------------------------------------------------------------------
// Date difference port checker
// Watches the ports of the date difference unit for timing and sign slips.
// ----------------------------------------------------------------------------
module sddd_checker (
   input logic                                     clock,
   input logic                                     reset,
   input logic                                     start,
   input logic                                     busy,
   input logic [sddd_pkg::DAY_WIDTH-1:0]           req_first_day,
   input logic [sddd_pkg::MONTH_WIDTH-1:0]         req_first_month,
   input logic [sddd_pkg::YEAR_WIDTH-1:0]          req_first_year,
   input logic [sddd_pkg::DAY_WIDTH-1:0]           req_second_day,
   input logic [sddd_pkg::MONTH_WIDTH-1:0]         req_second_month,
   input logic [sddd_pkg::YEAR_WIDTH-1:0]          req_second_year,
   input logic                                     req_count_end_day,
   input logic                                     rsp_valid,
   input logic signed [sddd_pkg::RESULT_WIDTH-1:0] rsp_day_difference
);
   import sddd_pkg::*;

   logic taken;
   logic same_date;
   logic later_year;

   assign taken      = start && !busy;
   assign same_date  = req_first_day == req_second_day && req_first_month == req_second_month
                    && req_first_year == req_second_year;
   // The first year is widened by one bit so that the largest field value cannot wrap.
   assign later_year = req_first_year != '0 && req_second_year <= YEAR_WIDTH'(400)
                    && {1'b0, req_second_year} > {1'b0, req_first_year} + (YEAR_WIDTH+1)'(1);

   // Every response answers a request that was taken earlier.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(taken, PIPE_LATENCY))
      else $error("response without a matching request");

   // A request taken with no reset since is always answered.
   assert property (@(posedge clock) disable iff (reset)
      ($past(taken, PIPE_LATENCY) && !$past(reset, 1) && !$past(reset, 2)
       && !$past(reset, 3) && !$past(reset, 4) && !$past(reset, 5)
       && !$past(reset, 6)) |-> rsp_valid)
      else $error("request lost in the pipeline");

   // Equal dates without the end day give zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(same_date && !req_count_end_day, PIPE_LATENCY))
      |-> rsp_day_difference == '0)
      else $error("equal dates gave a nonzero difference");

   // A second date in a clearly later year gives a positive count.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(later_year, PIPE_LATENCY))
      |-> rsp_day_difference > $signed(RESULT_WIDTH'(0)))
      else $error("later second date gave a count that is not positive");

endmodule

bind signed_date_difference_days_unit sddd_checker u_sddd_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .req_first_day      (req_first_day),
   .req_first_month    (req_first_month),
   .req_first_year     (req_first_year),
   .req_second_day     (req_second_day),
   .req_second_month   (req_second_month),
   .req_second_year    (req_second_year),
   .req_count_end_day  (req_count_end_day),
   .rsp_valid          (rsp_valid),
   .rsp_day_difference (rsp_day_difference)
);
